/* rtl/core/crx_pkg.sv */
// Package for the command frame receiver core.
// Holds shared widths, register indexes, parse phases and the frame descriptor type.
// No dependencies.
package crx_pkg;

  localparam int MAX_HEADER_DEF   = 4;
  localparam int MAX_COMMANDS_DEF = 4;
  localparam int MAX_PAYLOAD_DEF  = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int BYTE_W     = 8;
  localparam int CMD_W      = 2;
  localparam int POS_W      = 5;
  localparam int CNT_W      = 7;
  localparam int OUT_W      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_LENGTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND_CODES   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LENGTHS = 3'd4;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_CMD,
    PH_PAYLOAD,
    PH_CHECK
  } phase_t;

  typedef struct packed {
    logic             bank;
    logic [CMD_W-1:0] cmd;
    logic [CNT_W-1:0] count;
  } desc_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

/* rtl/core/crx_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module crx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/crx_queue.sv */
// Two-entry descriptor queue between the frame parser and the emitter.
// Depends on crx_pkg.
module crx_queue
  import crx_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output desc_t pop_desc,
  output logic  full,
  output logic  empty
);

  desc_t      entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_desc = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      priority case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/crx_front.sv */
// Frame parser: configuration registers, header hunt, command lookup,
// payload store into two RAM banks and checksum test. Depends on crx_pkg.
module crx_front
  import crx_pkg::*;
#(
  parameter int MAX_HEADER   = MAX_HEADER_DEF,
  parameter int MAX_COMMANDS = MAX_COMMANDS_DEF,
  parameter int MAX_PAYLOAD  = MAX_PAYLOAD_DEF,
  parameter int PW           = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [BYTE_W-1:0]     s_tdata,
  input  logic                  q_full,
  output logic                  q_push,
  output desc_t                 q_desc,
  output logic                  ram_we,
  output logic [PW:0]           ram_waddr,
  output logic [BYTE_W-1:0]     ram_wdata,
  input  release_t              rel,
  output logic [1:0]            bank_busy
);

  localparam int MAXLEN = (MAX_HEADER > MAX_PAYLOAD) ? MAX_HEADER : MAX_PAYLOAD;
  localparam int CW     = $clog2(MAXLEN + 1);

  logic [31:0] header_bytes;
  logic [2:0]  header_length;
  logic [2:0]  command_count;
  logic [31:0] command_codes;
  logic [23:0] payload_lengths;

  phase_t            phase, phase_next;
  logic [CW-1:0]     pos, pos_next;
  logic [BYTE_W-1:0] running_xor, running_xor_next;
  logic [CMD_W-1:0]  cur_cmd, cur_cmd_next;
  logic              wr_bank, wr_bank_next;
  logic [1:0]        busy, busy_next;

  logic              accept;
  logic [CW-1:0]     pos_inc;
  logic [7:0]        hdr_len;
  logic [BYTE_W-1:0] hdr_byte;
  logic [63:0]       hdr_ext;
  logic [63:0]       codes_ext;
  logic [3:0]        cnt_eff;
  logic              found;
  logic [CMD_W-1:0]  hit_cmd;
  logic [5:0]        hit_len_raw;
  logic [5:0]        cur_len_raw;
  logic [7:0]        cur_len;
  logic              hdr_match;
  logic              hdr_done;
  logic              pay_done;
  logic              sum_good;

  assign accept    = s_tvalid && s_tready;
  assign pos_inc   = pos + CW'(1);
  assign hdr_ext   = {32'd0, header_bytes};
  assign codes_ext = {32'd0, command_codes};
  assign bank_busy = busy;

  always_comb begin
    hdr_len = (header_length == 3'd0) ? 8'd1 : {5'd0, header_length};
    if (hdr_len > 8'(MAX_HEADER)) begin
      hdr_len = 8'(MAX_HEADER);
    end
    hdr_byte = 8'd0;
    for (int i = 0; i < 8; i++) begin
      if (8'(pos) == 8'(i)) begin
        hdr_byte = hdr_ext[8*i +: 8];
      end
    end
  end

  always_comb begin
    cnt_eff = (command_count > 3'(MAX_COMMANDS)) ? 4'(MAX_COMMANDS) : {1'b0, command_count};
    found   = 1'b0;
    hit_cmd = '0;
    for (int c = MAX_COMMANDS - 1; c >= 0; c--) begin
      if (4'(c) < cnt_eff && codes_ext[8*c +: 8] == s_tdata) begin
        found   = 1'b1;
        hit_cmd = CMD_W'(c);
      end
    end
  end

  always_comb begin
    hit_len_raw = payload_lengths[6*hit_cmd +: 6];
    cur_len_raw = payload_lengths[6*cur_cmd +: 6];
    cur_len     = (cur_len_raw > 6'(MAX_PAYLOAD)) ? 8'(MAX_PAYLOAD) : {2'd0, cur_len_raw};
  end

  assign hdr_match = (s_tdata == hdr_byte);
  assign hdr_done  = (8'(pos_inc) >= hdr_len);
  assign pay_done  = (8'(pos_inc) >= cur_len) || (8'(pos_inc) >= 8'(MAX_PAYLOAD));
  assign sum_good  = (running_xor == s_tdata);

  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        PH_HUNT: begin
          if (hdr_match && hdr_done) begin
            phase_next = PH_CMD;
          end
        end
        PH_CMD: begin
          if (!found) begin
            phase_next = PH_HUNT;
          end else if (hit_len_raw != 6'd0) begin
            phase_next = PH_PAYLOAD;
          end else begin
            phase_next = PH_CHECK;
          end
        end
        PH_PAYLOAD: begin
          if (pay_done) begin
            phase_next = PH_CHECK;
          end
        end
        PH_CHECK: phase_next = PH_HUNT;
        default:  phase_next = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    s_tready = !((phase == PH_PAYLOAD) && busy[wr_bank]) && !((phase == PH_CHECK) && q_full);
    ram_we       = accept && (phase == PH_PAYLOAD);
    ram_waddr    = {wr_bank, pos[PW-1:0]};
    ram_wdata    = s_tdata;
    q_push       = accept && (phase == PH_CHECK) && sum_good;
    q_desc.bank  = wr_bank;
    q_desc.cmd   = cur_cmd;
    q_desc.count = CNT_W'(pos);
  end

  always_comb begin
    pos_next         = pos;
    running_xor_next = running_xor;
    cur_cmd_next     = cur_cmd;
    wr_bank_next     = wr_bank;
    busy_next        = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (accept) begin
      unique case (phase)
        PH_HUNT: begin
          if (!hdr_match) begin
            pos_next = '0;
          end else if (hdr_done) begin
            pos_next         = '0;
            running_xor_next = '0;
          end else begin
            pos_next = pos_inc;
          end
        end
        PH_CMD: begin
          pos_next = '0;
          if (found) begin
            cur_cmd_next     = hit_cmd;
            running_xor_next = running_xor ^ s_tdata;
          end
        end
        PH_PAYLOAD: begin
          pos_next         = pos_inc;
          running_xor_next = running_xor ^ s_tdata;
        end
        PH_CHECK: begin
          pos_next = '0;
          if (sum_good && pos != '0) begin
            busy_next[wr_bank] = 1'b1;
            wr_bank_next       = ~wr_bank;
          end
        end
        default: pos_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes    <= '0;
      header_length   <= 3'd1;
      command_count   <= '0;
      command_codes   <= '0;
      payload_lengths <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER_BYTES:    header_bytes    <= cfg_data;
        REG_HEADER_LENGTH:   header_length   <= cfg_data[2:0];
        REG_COMMAND_COUNT:   command_count   <= cfg_data[2:0];
        REG_COMMAND_CODES:   command_codes   <= cfg_data;
        REG_PAYLOAD_LENGTHS: payload_lengths <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      pos         <= '0;
      running_xor <= '0;
      cur_cmd     <= '0;
      wr_bank     <= 1'b0;
      busy        <= '0;
    end else begin
      phase       <= phase_next;
      pos         <= pos_next;
      running_xor <= running_xor_next;
      cur_cmd     <= cur_cmd_next;
      wr_bank     <= wr_bank_next;
      busy        <= busy_next;
    end
  end

endmodule

/* rtl/core/crx_back.sv */
// Result emitter: takes frame descriptors, reads the payload bank and streams one result
// per cycle, unless m_tready stalls, via a read stage and an output register. Depends on crx_pkg.
module crx_back
  import crx_pkg::*;
#(
  parameter int PW = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  output logic              q_pop,
  input  desc_t             q_desc,
  output logic              ram_re,
  output logic [PW:0]       ram_raddr,
  input  logic [BYTE_W-1:0] ram_rdata,
  output release_t          rel,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,
  output logic              m_tlast
);

  logic             act_valid;
  logic             act_bank;
  logic [CMD_W-1:0] act_cmd;
  logic [CNT_W-1:0] act_n;
  logic [PW-1:0]    k;

  logic             s1_valid;
  logic [CMD_W-1:0] s1_cmd;
  logic [POS_W-1:0] s1_pos;
  logic             s1_hp;
  logic             s1_last;

  logic out_load;
  logic s1_ready;
  logic issue;
  logic empty_frame;
  logic last_k;

  assign out_load    = !m_tvalid || m_tready;
  assign s1_ready    = !s1_valid || out_load;
  assign issue       = act_valid && s1_ready;
  assign empty_frame = (act_n == '0);
  assign last_k      = (CNT_W'(k) + CNT_W'(1) == act_n);
  assign q_pop       = !act_valid && !q_empty;
  assign ram_re      = issue && !empty_frame;
  assign ram_raddr   = {act_bank, k};
  assign rel.valid   = issue && !empty_frame && last_k;
  assign rel.bank    = act_bank;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      act_bank <= q_desc.bank;
      act_cmd  <= q_desc.cmd;
      act_n    <= q_desc.count;
      k        <= '0;
    end else if (issue) begin
      k <= k + PW'(1);
    end
    if (issue) begin
      s1_cmd  <= act_cmd;
      s1_pos  <= empty_frame ? '0 : POS_W'(k);
      s1_hp   <= !empty_frame;
      s1_last <= empty_frame || last_k;
    end
    if (out_load) begin
      m_tdata <= {s1_hp, s1_pos, (s1_hp ? ram_rdata : 8'd0), s1_cmd};
      m_tlast <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid <= 1'b0;
      s1_valid  <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (q_pop) begin
        act_valid <= 1'b1;
      end else if (issue && (empty_frame || last_k)) begin
        act_valid <= 1'b0;
      end
      if (s1_ready) begin
        s1_valid <= issue;
      end
      if (out_load) begin
        m_tvalid <= s1_valid;
      end
    end
  end

endmodule

/* rtl/core/command_frame_receiver_core.sv */
// Top level of the command frame receiver core.
// Depends on crx_pkg, crx_ram, crx_queue, crx_front and crx_back.
//
// Takes one received byte per cycle on the slave stream, hunts for the
// configured sync header, looks up the command byte, stores its payload and
// checks the XOR checksum. A good frame produces one result per payload byte
// (or one result with has_payload low for an empty payload), last marked by
// tlast. Input runs at one byte per cycle; it stalls only when the parser
// would write a payload bank that is still being emitted (two banks) or the
// two-entry frame queue is full at the checksum byte. Results leave at one
// per cycle while m_tready is high, through the RAM read stage and the output
// register; a new frame is picked up only after the last one is fully issued.
module command_frame_receiver_core
  import crx_pkg::*;
#(
  parameter int MAX_HEADER   = MAX_HEADER_DEF,
  parameter int MAX_COMMANDS = MAX_COMMANDS_DEF,
  parameter int MAX_PAYLOAD  = MAX_PAYLOAD_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [BYTE_W-1:0]     s_tdata,   // rx_byte[7:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // command_index[1:0], data_byte[9:2],
                                           // byte_position[14:10], has_payload[15]
  output logic                  m_tlast
);

  localparam int PW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int DEPTH = 2 ** (PW + 1);

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  desc_t             q_in;
  desc_t             q_out;
  logic              ram_we;
  logic [PW:0]       ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [PW:0]       ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  release_t          rel;
  logic [1:0]        bank_busy;

  crx_front #(
    .MAX_HEADER   (MAX_HEADER),
    .MAX_COMMANDS (MAX_COMMANDS),
    .MAX_PAYLOAD  (MAX_PAYLOAD),
    .PW           (PW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (q_in),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .rel       (rel),
    .bank_busy (bank_busy)
  );

  crx_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_desc (q_in),
    .pop       (q_pop),
    .pop_desc  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  crx_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  crx_back #(
    .PW (PW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_desc    (q_out),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .rel       (rel),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("frame queue overflow");

  a_queue_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty) else $error("frame queue underflow");

  a_write_free_bank: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !bank_busy[ram_waddr[PW]]) else $error("payload write into busy bank");

  a_release_busy_bank: assert property (@(posedge clk) disable iff (rst)
    rel.valid |-> bank_busy[rel.bank]) else $error("release of idle bank");

endmodule
